/* rtl/sfrx_pkg.sv */
package sfrx_pkg;

   localparam logic [7:0] HEAD1_BYTE = 8'hAA;
   localparam logic [7:0] HEAD2_BYTE = 8'h55;
   localparam logic [7:0] TAIL1_BYTE = 8'h0D;
   localparam logic [7:0] TAIL2_BYTE = 8'h0A;

   localparam int STORE_DEPTH = 64;
   localparam int IDX_W       = 6;
   localparam int LEN_W       = 7;
   // two banks of payload store, one bit of bank select above the index
   localparam int ADDR_W      = IDX_W + 1;

   typedef enum logic [2:0] {
      PH_HEAD1,
      PH_HEAD2,
      PH_CMD,
      PH_LEN,
      PH_DATA,
      PH_SUM,
      PH_TAIL1,
      PH_TAIL2
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SHOW
   } back_state_type;

   typedef struct packed {
      logic [7:0]       command;
      logic [LEN_W-1:0] length;
      logic             bank;
   } frame_desc_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic [1:0]     count;
      frame_desc_type head;
   } queue_status_type;

endpackage

/* rtl/sfrx_front.sv */
module sfrx_front
   import sfrx_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     byte_data,
   output store_wr_type   store_wr,
   output logic           push,
   output frame_desc_type push_desc
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [7:0]       xor_ff, xor_in;
   logic             bank_ff, bank_in;
   logic [LEN_W-1:0] count_next;
   logic             len_ok;

   assign count_next = count_ff + LEN_W'(1);
   assign len_ok     = byte_data <= 8'(MAX_PAYLOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         cmd_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         bank_ff  <= bank_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEAD1: if (byte_data == HEAD1_BYTE) phase_in = PH_HEAD2;
            PH_HEAD2: phase_in = (byte_data == HEAD2_BYTE) ? PH_CMD : PH_HEAD1;
            PH_CMD:   phase_in = PH_LEN;
            PH_LEN: begin
               if (!len_ok)
                  phase_in = PH_HEAD1;
               else
                  phase_in = (byte_data != 8'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA:  if (count_next >= len_ff) phase_in = PH_SUM;
            PH_SUM:   phase_in = (xor_ff == byte_data) ? PH_TAIL1 : PH_HEAD1;
            PH_TAIL1: phase_in = (byte_data == TAIL1_BYTE) ? PH_TAIL2 : PH_HEAD1;
            PH_TAIL2: phase_in = PH_HEAD1;
            default:  phase_in = PH_HEAD1;
         endcase
      end
   end

   always_comb begin
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      bank_in       = bank_ff;
      store_wr.en   = 1'b0;
      store_wr.addr = {bank_ff, count_ff[IDX_W-1:0]};
      store_wr.data = byte_data;
      push          = 1'b0;
      push_desc     = '{command: cmd_ff, length: len_ff, bank: bank_ff};
      if (byte_valid) begin
         unique case (phase_ff)
            PH_CMD: cmd_in = byte_data;
            PH_LEN: begin
               if (len_ok) begin
                  len_in   = byte_data[LEN_W-1:0];
                  count_in = '0;
                  xor_in   = cmd_ff ^ byte_data;
               end
            end
            PH_DATA: begin
               store_wr.en = 1'b1;
               xor_in      = xor_ff ^ byte_data;
               count_in    = count_next;
            end
            PH_TAIL2: begin
               if (byte_data == TAIL2_BYTE) begin
                  push    = 1'b1;
                  bank_in = ~bank_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

/* rtl/sfrx_queue.sv */
module sfrx_queue
   import sfrx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_desc_type   push_desc,
   input  logic             pop,
   output queue_status_type status
);

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

   assign status.count = count_ff;
   assign status.head  = entry_ff[rd_ptr_ff];

endmodule

/* rtl/sfrx_back.sv */
module sfrx_back
   import sfrx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  store_wr_type     store_wr,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_command,
   output logic [LEN_W-1:0] out_payload_len,
   output logic [IDX_W-1:0] out_payload_index,
   output logic [7:0]       out_payload_byte,
   output logic             out_has_payload,
   output logic             out_last
);

   logic [7:0] store_mem [2*STORE_DEPTH];
   logic [7:0] rd_data_ff;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             has_pl;
   logic             is_last;
   logic             rd_en;

   assign has_pl  = q_status.head.length != '0;
   assign is_last = !has_pl || ({1'b0, idx_ff} + LEN_W'(1) == q_status.head.length);

   always_ff @(posedge clock) begin
      if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
      if (rd_en) rd_data_ff <= store_mem[{q_status.head.bank, idx_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (q_status.count != 2'd0) state_in = BK_READ;
         BK_READ: state_in = BK_SHOW;
         BK_SHOW: if (out_ready) state_in = is_last ? BK_IDLE : BK_READ;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      rd_en     = 1'b0;
      pop       = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         BK_IDLE: idx_in = '0;
         BK_READ: rd_en = 1'b1;
         BK_SHOW: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (is_last)
                  pop = 1'b1;
               else
                  idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign out_command       = q_status.head.command;
   assign out_payload_len   = q_status.head.length;
   assign out_payload_index = idx_ff;
   assign out_payload_byte  = has_pl ? rd_data_ff : 8'd0;
   assign out_has_payload   = has_pl;
   assign out_last          = is_last;

endmodule

/* rtl/serial_frame_receiver_xor_check_core.sv */
// First result: the queue registers a frame's descriptor at its final tail transfer; an idle
//   emitter then reads the store and holds that result. Throughput: one received byte per
//   cycle in while not stalled; out, a store read then an output hold for every result.
// Request side stalls only while two completed frames still wait to be emitted.
// Reset (synchronous, active high) clears the parser, queue and emitter control; the
//   payload store is not cleared and needs no clearing pass.
module serial_frame_receiver_xor_check_core
   import sfrx_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_command,
   output logic [LEN_W-1:0] rsp_payload_len,
   output logic [IDX_W-1:0] rsp_payload_index,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_has_payload,
   output logic             rsp_last
);

   store_wr_type     store_wr;
   logic             push;
   frame_desc_type   push_desc;
   logic             pop;
   queue_status_type q_status;
   logic             req_xfer;

   // Each queued frame owns one bank of the store; with fewer than two frames waiting the
   // bank the parser fills is free, so hold off byte transfers only when both are taken.
   assign req_ready = q_status.count != 2'd2;
   assign req_xfer  = req_valid && req_ready;

   // Front: hunt for headers, check length, checksum and tails, write payload into its bank.
   sfrx_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_xfer),
      .byte_data  (req_rx_byte),
      .store_wr   (store_wr),
      .push       (push),
      .push_desc  (push_desc)
   );

   // Short queue of completed frame descriptors between parser and emitter.
   sfrx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .status    (q_status)
   );

   // Back: walk the head frame's payload and present one result per transfer;
   // drop the descriptor after its last result.
   sfrx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .store_wr          (store_wr),
      .q_status          (q_status),
      .pop               (pop),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .out_command       (rsp_command),
      .out_payload_len   (rsp_payload_len),
      .out_payload_index (rsp_payload_index),
      .out_payload_byte  (rsp_payload_byte),
      .out_has_payload   (rsp_has_payload),
      .out_last          (rsp_last)
   );

   // The parser never writes into the bank of a frame still waiting to be emitted.
   a_bank_separate: assert property (@(posedge clock) disable iff (reset)
      (store_wr.en && q_status.count != 2'd0) |-> store_wr.addr[ADDR_W-1] != q_status.head.bank)
      else $error("payload write into bank of pending frame");

   // A result is only shown while a frame descriptor is queued.
   a_rsp_has_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> q_status.count != 2'd0)
      else $error("response valid with empty frame queue");

   // No descriptor is pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_status.count != 2'd2)
      else $error("frame queue overflow");

   // Final result transfer releases exactly one descriptor.
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last && !push) |=>
         q_status.count == $past(q_status.count) - 2'd1)
      else $error("descriptor not released after last result");

endmodule

/* dv/tb_serial_frame_receiver_xor_check_core.sv */
`timescale 1ns / 100ps

import sfrx_pkg::*;

typedef struct packed {
   logic [7:0]       command;
   logic [LEN_W-1:0] payload_len;
   logic [IDX_W-1:0] payload_index;
   logic [7:0]       payload_byte;
   logic             has_payload;
   logic             last;
} frame_result_type;

// Frame parser twin and queue of the results that completed frames are owed.
class frame_scoreboard;
   int               max_len;
   phase_type        phase;
   logic [7:0]       cmd_q;
   logic [LEN_W-1:0] len_q;
   logic [LEN_W-1:0] count_q;
   logic [7:0]       sum_q;
   logic [7:0]       payload_mem [STORE_DEPTH];
   frame_result_type owed_results [$];
   int               faults;
   int               results_seen;
   int               frames_passed;
   int               frames_dropped;

   function new(int max_len);
      this.max_len   = max_len;
      phase          = PH_HEAD1;
      cmd_q          = '0;
      len_q          = '0;
      count_q        = '0;
      sum_q          = '0;
      faults         = 0;
      results_seen   = 0;
      frames_passed  = 0;
      frames_dropped = 0;
   endfunction

   // Advance the parser by one received byte; queue the frame's results on a good tail.
   function void note_rx_byte(logic [7:0] b);
      frame_result_type r;
      int               i;
      case (phase)
         PH_HEAD1: if (b == HEAD1_BYTE) phase = PH_HEAD2;
         PH_HEAD2: phase = (b == HEAD2_BYTE) ? PH_CMD : PH_HEAD1;
         PH_CMD: begin
            cmd_q = b;
            phase = PH_LEN;
         end
         PH_LEN: begin
            if (b > max_len) begin
               phase = PH_HEAD1;
               frames_dropped++;
            end else begin
               len_q   = b[LEN_W-1:0];
               count_q = '0;
               sum_q   = cmd_q ^ b;
               phase   = (b != 8'h00) ? PH_DATA : PH_SUM;
            end
         end
         PH_DATA: begin
            payload_mem[count_q[IDX_W-1:0]] = b;
            sum_q   = sum_q ^ b;
            count_q = count_q + 1'b1;
            if (count_q >= len_q) phase = PH_SUM;
         end
         PH_SUM: begin
            phase = (sum_q == b) ? PH_TAIL1 : PH_HEAD1;
            if (sum_q != b) frames_dropped++;
         end
         PH_TAIL1: begin
            phase = (b == TAIL1_BYTE) ? PH_TAIL2 : PH_HEAD1;
            if (b != TAIL1_BYTE) frames_dropped++;
         end
         PH_TAIL2: begin
            if (b == TAIL2_BYTE) begin
               frames_passed++;
               r.command     = cmd_q;
               r.payload_len = len_q;
               if (len_q == 0) begin
                  r.payload_index = '0;
                  r.payload_byte  = '0;
                  r.has_payload   = 1'b0;
                  r.last          = 1'b1;
                  owed_results.push_back(r);
               end else begin
                  for (i = 0; i < len_q; i++) begin
                     r.payload_index = IDX_W'(i);
                     r.payload_byte  = payload_mem[i];
                     r.has_payload   = 1'b1;
                     r.last          = (i == len_q - 1);
                     owed_results.push_back(r);
                  end
               end
            end else begin
               frames_dropped++;
            end
            phase = PH_HEAD1;
         end
         default: phase = PH_HEAD1;
      endcase
   endfunction

   task report_fault(string msg);
      faults++;
      $display("MISMATCH %0t: %s", $realtime, msg);
   endtask

   task check_result(frame_result_type got);
      frame_result_type want;
      results_seen++;
      if (owed_results.size() == 0) begin
         report_fault($sformatf("unexpected result cmd %02h len %0d idx %0d byte %02h",
                                got.command, got.payload_len, got.payload_index,
                                got.payload_byte));
         return;
      end
      want = owed_results.pop_front();
      if (got.command !== want.command || got.payload_len !== want.payload_len ||
          got.payload_index !== want.payload_index ||
          got.payload_byte !== want.payload_byte ||
          got.has_payload !== want.has_payload || got.last !== want.last) begin
         report_fault($sformatf(
            "cmd/len/idx/byte/has/last want %02h/%0d/%0d/%02h/%b/%b got %02h/%0d/%0d/%02h/%b/%b",
            want.command, want.payload_len, want.payload_index, want.payload_byte,
            want.has_payload, want.last, got.command, got.payload_len, got.payload_index,
            got.payload_byte, got.has_payload, got.last));
      end
   endtask
endclass

module tb_serial_frame_receiver_xor_check_core;

   localparam int MAX_PAYLOAD          = 64;
   // random part; with the opening and the closing full-length frame about 180 bytes in all
   localparam int RANDOM_BYTE_TARGET   = 80;
   // long receiver hold-off: enough for several short frames to complete behind it
   localparam int RECEIVER_HOLD_CYCLES = 500;
   // slowest legal quiet stretch is the hold-off plus one stall; allow several times that
   localparam int STALL_LIMIT          = 3000;
   localparam int DRAIN_CYCLES         = 20;
   localparam int OPENING_COUNT        = 29;

   typedef enum int {
      FLAW_NONE,
      FLAW_HEAD2,
      FLAW_LEN,
      FLAW_SUM,
      FLAW_TAIL1,
      FLAW_TAIL2
   } frame_flaw_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [7:0]       req_rx_byte;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [7:0]       rsp_command;
   logic [LEN_W-1:0] rsp_payload_len;
   logic [IDX_W-1:0] rsp_payload_index;
   logic [7:0]       rsp_payload_byte;
   logic             rsp_has_payload;
   logic             rsp_last;

   frame_scoreboard sb;
   int              bytes_sent   = 0;
   int              idle_cycles  = 0;
   bit              sender_burst = 1'b0;
   bit              hold_request = 1'b0;

   // Directed opening: a second header that is itself AA, a zero-length frame with
   // command FF, a length one above the limit, a bad second tail, then a one-byte frame.
   logic [7:0] opening_bytes [OPENING_COUNT] = '{
      HEAD1_BYTE, HEAD1_BYTE,
      HEAD1_BYTE, HEAD2_BYTE, 8'hFF, 8'h00, 8'hFF, TAIL1_BYTE, TAIL2_BYTE,
      HEAD1_BYTE, HEAD2_BYTE, 8'h00, 8'h41,
      HEAD1_BYTE, HEAD2_BYTE, 8'h00, 8'h01, 8'hFF, 8'hFE, TAIL1_BYTE, 8'h0B,
      HEAD1_BYTE, HEAD2_BYTE, 8'h00, 8'h01, 8'h00, 8'h01, TAIL1_BYTE, TAIL2_BYTE
   };

   serial_frame_receiver_xor_check_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_command       (rsp_command),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_last          (rsp_last)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Sample both channels at the rising edge; note the request transfer before checking
   // the response so that a frame's results are always owed before they can arrive.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_rx_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{command:       rsp_command,
                              payload_len:   rsp_payload_len,
                              payload_index: rsp_payload_index,
                              payload_byte:  rsp_payload_byte,
                              has_payload:   rsp_has_payload,
                              last:          rsp_last});
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                  idle_cycles, sb.owed_results.size());
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte after a random gap and hold it until the transfer.
   // Enter and leave at a falling edge; raise valid only once per step.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
      logic [7:0] value;
      value = 8'($urandom_range(0, 255));
      if (value == avoid) value = ~value;
      return value;
   endfunction

   // Build a frame with random payload; a flaw cuts it short at the broken byte,
   // which is where the parser drops it and goes back to hunting.
   task automatic send_frame(input logic [7:0] command, input int len,
                             input frame_flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] value;
      sum = command ^ 8'(len);
      send_byte(HEAD1_BYTE);
      if (flaw == FLAW_HEAD2) begin
         // a repeated first header byte is a bad second header too
         value = ($urandom_range(0, 2) == 0) ? HEAD1_BYTE : byte_other_than(HEAD2_BYTE);
         send_byte(value);
         return;
      end
      send_byte(HEAD2_BYTE);
      send_byte(command);
      if (flaw == FLAW_LEN) begin
         send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
         return;
      end
      send_byte(8'(len));
      repeat (len) begin
         value = 8'($urandom_range(0, 255));
         sum   = sum ^ value;
         send_byte(value);
      end
      if (flaw == FLAW_SUM) begin
         send_byte(sum ^ 8'($urandom_range(1, 255)));
         return;
      end
      send_byte(sum);
      if (flaw == FLAW_TAIL1) begin
         send_byte(byte_other_than(TAIL1_BYTE));
         return;
      end
      send_byte(TAIL1_BYTE);
      send_byte((flaw == FLAW_TAIL2) ? byte_other_than(TAIL2_BYTE) : TAIL2_BYTE);
   endtask

   // Receiver: draw a stall per result, with bursts of no stalling. Once the random
   // part starts, hold off for a long stretch so completed frames pile up and the
   // request side backs up.
   initial begin : receiver
      int gap;
      int served;
      bit burst;
      bit hold_done;
      served    = 0;
      burst     = 1'b0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (served % 16 == 0 && $urandom_range(0, 2) == 0) burst = !burst;
         if (hold_request && !hold_done) begin
            gap       = RECEIVER_HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            gap = burst ? 0 : $urandom_range(0, 8);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         served++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      frame_flaw_type flaw;
      int             pick;
      int             len;
      sb          = new(MAX_PAYLOAD);
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      // Random part: mostly well-formed frames, some broken ones, a little line noise.
      hold_request = 1'b1;
      while (bytes_sent < OPENING_COUNT + RANDOM_BYTE_TARGET) begin
         if ($urandom_range(0, 3) == 0) sender_burst = !sender_burst;
         pick = $urandom_range(0, 19);
         if (pick < 13) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(56, MAX_PAYLOAD)
                                               : $urandom_range(0, 8);
            send_frame(8'($urandom_range(0, 255)), len, FLAW_NONE);
         end else if (pick < 18) begin
            flaw = frame_flaw_type'($urandom_range(FLAW_HEAD2, FLAW_TAIL2));
            send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), flaw);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      // fill one whole bank of the payload store once
      send_frame(8'($urandom_range(0, 255)), MAX_PAYLOAD, FLAW_NONE);
      req_valid <= 1'b0;

      // Drain: wait for every owed result, then give stray results time to show.
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d received bytes: %0d frames passed, %0d dropped, %0d results",
               bytes_sent, sb.frames_passed, sb.frames_dropped, sb.results_seen);
      $display("receiver held off %0d cycles once with the sender still offering bytes",
               RECEIVER_HOLD_CYCLES);
      if (sb.faults == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", sb.faults);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/sfrx_pkg.sv
rtl/sfrx_front.sv
rtl/sfrx_queue.sv
rtl/sfrx_back.sv
rtl/serial_frame_receiver_xor_check_core.sv
dv/tb_serial_frame_receiver_xor_check_core.sv
